>>> hdl/two_sided_audio_pool_allocator_core_macros.svh
// Assertion macros shared by the pool allocator modules
`ifndef TWO_SIDED_AUDIO_POOL_ALLOCATOR_CORE_MACROS_SVH
`define TWO_SIDED_AUDIO_POOL_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define TSAPA_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TSAPA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/tsapa_pkg.sv
// Types, constants and codes of the two-sided pool allocator
package tsapa_pkg;

    localparam int ADDR_W          = 24;
    localparam int ID_W            = 8;
    localparam int SIZE_W          = 24;
    localparam int UNIT_W          = 8;
    localparam int PROD_W          = SIZE_W + UNIT_W;
    localparam int PC_W            = ADDR_W + 1;
    localparam int TW              = ADDR_W + 3;
    localparam int SLOT_W          = ID_W + 1;
    localparam int STATUS_DEPTH    = 256;
    localparam int STAT_AW         = $clog2(STATUS_DEPTH);
    localparam int PERSIST_ENTRIES = 32;
    localparam int PIDX_W          = (PERSIST_ENTRIES > 1) ? $clog2(PERSIST_ENTRIES) : 1;
    localparam int PCNT_W          = $clog2(PERSIST_ENTRIES + 1);
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_W           = 24;

    localparam logic [SLOT_W-1:0] SLOT_EMPTY  = 9'h100;
    localparam logic [3:0]        ALIGN_MASK  = 4'hF;
    localparam logic [4:0]        ALIGN_BYTES = 5'h10;

    // load status codes
    localparam logic [1:0] ST_NOT_LOADED  = 2'd0;
    localparam logic [1:0] ST_IN_PROGRESS = 2'd1;
    localparam logic [1:0] ST_COMPLETE    = 2'd2;
    localparam logic [1:0] ST_DISCARDABLE = 2'd3;

    // operations
    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_STATUS = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // allocation modes
    localparam logic [1:0] MODE_TEMP    = 2'd0;
    localparam logic [1:0] MODE_PERSIST = 2'd1;
    localparam logic [1:0] MODE_FALLBK  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PBASE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLEN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TBASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TLEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BANK  = 3'd4;

    // datapath actions
    localparam logic [3:0] A_NONE   = 4'd0;
    localparam logic [3:0] A_LATCH  = 4'd1;
    localparam logic [3:0] A_STATUS = 4'd2;
    localparam logic [3:0] A_CLEAR  = 4'd3;
    localparam logic [3:0] A_SRCH   = 4'd4;
    localparam logic [3:0] A_SLOTS  = 4'd5;
    localparam logic [3:0] A_NULL   = 4'd6;
    localparam logic [3:0] A_MUL    = 4'd7;
    localparam logic [3:0] A_PALLOC = 4'd8;
    localparam logic [3:0] A_TRD    = 4'd9;
    localparam logic [3:0] A_TSEL   = 4'd10;
    localparam logic [3:0] A_TOVL   = 4'd11;
    localparam logic [3:0] A_TFIN   = 4'd12;

    typedef struct packed {
        logic [1:0]        op;
        logic [1:0]        mode;
        logic [ID_W-1:0]   item_id;
        logic [SIZE_W-1:0] size_bytes;
        logic [UNIT_W-1:0] unit_count;
        logic [1:0]        new_status;
    } in_t;

    typedef struct packed {
        logic              kind;
        logic              ok;
        logic [ADDR_W-1:0] address;
        logic [ID_W-1:0]   evicted_id;
        logic              stop_users;
        logic              last;
    } res_t;

    typedef struct packed {
        logic [3:0] act;
    } ctl_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] mode;
        logic       srch_end;
        logic       hit;
        logic       fit;
        logic       tnull;
    } dp_sts_t;

endpackage

>>> hdl/tsapa_ctrl.sv
// Sequencing state machine of the pool allocator
`include "two_sided_audio_pool_allocator_core_macros.svh"

module tsapa_ctrl
    import tsapa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  dp_sts_t  sts,
    output ctl_cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_SRCH = 3'd2;
    localparam logic [2:0] S_PCHK = 3'd3;
    localparam logic [2:0] S_TRD  = 3'd4;
    localparam logic [2:0] S_TSEL = 3'd5;
    localparam logic [2:0] S_TOVL = 3'd6;
    localparam logic [2:0] S_TFIN = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // next state and action
    always_comb
    begin
        state_next = state_reg;
        cmd.act    = A_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.act    = A_LATCH;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (sts.op)
                    OP_STATUS:
                    begin
                        cmd.act    = A_STATUS;
                        state_next = S_IDLE;
                    end
                    OP_CLEAR:
                    begin
                        cmd.act    = A_CLEAR;
                        state_next = S_IDLE;
                    end
                    OP_LOOKUP:
                    begin
                        if (sts.mode != MODE_TEMP)
                        begin
                            state_next = S_SRCH;
                        end
                        else
                        begin
                            cmd.act    = A_SLOTS;
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        if (sts.mode == MODE_TEMP)
                        begin
                            cmd.act    = A_TRD;
                            state_next = S_TSEL;
                        end
                        else
                        begin
                            cmd.act    = A_MUL;
                            state_next = S_PCHK;
                        end
                    end
                endcase
            end
            S_SRCH:
            begin
                if (sts.srch_end)
                begin
                    cmd.act    = (sts.mode == MODE_FALLBK) ? A_SLOTS : A_NULL;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.act = A_SRCH;
                    if (sts.hit)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_PCHK:
            begin
                cmd.act = A_PALLOC;
                if (!sts.fit && sts.mode == MODE_FALLBK)
                begin
                    state_next = S_TRD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_TRD:
            begin
                cmd.act    = A_TRD;
                state_next = S_TSEL;
            end
            S_TSEL:
            begin
                cmd.act    = A_TSEL;
                state_next = sts.tnull ? S_IDLE : S_TOVL;
            end
            S_TOVL:
            begin
                cmd.act    = A_TOVL;
                state_next = S_TFIN;
            end
            S_TFIN:
            begin
                cmd.act    = A_TFIN;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `TSAPA_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
    `TSAPA_ASSERT_NXT(a_ovl_then_fin, state_reg == S_TOVL, state_reg == S_TFIN, "overlap step not followed by final")

endmodule

>>> hdl/tsapa_dp.sv
// Datapath: pool state, status table, persistent list and result register
`include "two_sided_audio_pool_allocator_core_macros.svh"

module tsapa_dp
    import tsapa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  in_t                  in_item,
    input  ctl_cmd_t             cmd,
    output dp_sts_t              sts,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output res_t                 result,
    output logic                 result_valid
);

    // configuration
    logic [ADDR_W-1:0] pbase_reg, plen_reg, tbase_reg, tlen_reg;
    logic              bank_reg;

    in_t               item_reg;

    // memories
    logic [1:0]        status_mem [STATUS_DEPTH];
    logic [ID_W-1:0]   pid_mem    [PERSIST_ENTRIES];
    logic [ADDR_W-1:0] paddr_mem  [PERSIST_ENTRIES];

    logic [STATUS_DEPTH-1:0] svld_reg, svld_next;
    logic [1:0]              rd0_reg, rd1_reg;

    logic [PCNT_W-1:0] pcount_reg, pcount_next;
    logic [PC_W-1:0]   pcursor_reg, pcursor_next;
    logic [PCNT_W-1:0] sidx_reg, sidx_next;
    logic [PROD_W-1:0] prod_reg;

    logic [SLOT_W-1:0]     slot_id_reg   [2];
    logic [SLOT_W-1:0]     slot_id_next  [2];
    logic signed [TW-1:0]  slot_addr_reg [2];
    logic signed [TW-1:0]  slot_addr_next[2];
    logic signed [TW-1:0]  tcursor_reg, tcursor_next;
    logic                  nside_reg, nside_next;
    logic                  ovl_reg, ovl_next;
    logic                  oside_reg, oside_next;
    logic [ADDR_W-1:0]     ret_reg, ret_next;

    res_t res_reg, res_next;
    logic res_vld_reg, res_vld_next;

    // derived values
    logic signed [TW-1:0] tbase_x, tend_x, size_x, tcur0_x, new1_x;
    logic [PROD_W:0]      aligned;
    logic [PROD_W+1:0]    pend_sum, plimit;
    logic                 fit, hit, side, tnull;
    logic                 rc_side, rc_stop;
    logic [SLOT_W-1:0]    rc_id;
    logic [PIDX_W-1:0]    sidx_i;
    logic [STAT_AW-1:0]   id_i;

    assign tbase_x = {{(TW-ADDR_W){1'b0}}, tbase_reg};
    assign tend_x  = tbase_x + {{(TW-ADDR_W){1'b0}}, tlen_reg};
    assign size_x  = {{(TW-SIZE_W){1'b0}}, item_reg.size_bytes};
    assign tcur0_x = tbase_x + size_x;
    assign new1_x  = tend_x - size_x - {{(TW-5){1'b0}}, ALIGN_BYTES};

    // persistent fit check
    assign aligned  = ({1'b0, prod_reg} + {{(PROD_W-3){1'b0}}, ALIGN_MASK})
                      & ~{{(PROD_W-3){1'b0}}, ALIGN_MASK};
    assign pend_sum = {{(PROD_W+2-PC_W){1'b0}}, pcursor_reg} + {1'b0, aligned};
    assign plimit   = {{(PROD_W+2-ADDR_W){1'b0}}, pbase_reg}
                      + {{(PROD_W+2-ADDR_W){1'b0}}, plen_reg};
    assign fit      = (pcount_reg < PCNT_W'(PERSIST_ENTRIES)) && (pend_sum <= plimit);

    assign sidx_i = sidx_reg[PIDX_W-1:0];
    assign hit    = (pid_mem[sidx_i] == item_reg.item_id);
    assign id_i   = item_reg.item_id[STAT_AW-1:0];

    // side choice from the two slot statuses
    always_comb
    begin
        tnull = 1'b0;
        side  = 1'b0;
        if (rd0_reg == ST_NOT_LOADED)
            side = 1'b0;
        else if (rd1_reg == ST_NOT_LOADED)
            side = 1'b1;
        else if (rd0_reg == ST_DISCARDABLE && rd1_reg == ST_DISCARDABLE)
            side = nside_reg;
        else if (rd0_reg == ST_DISCARDABLE)
            side = 1'b0;
        else if (rd1_reg == ST_DISCARDABLE)
            side = 1'b1;
        else if (rd0_reg != ST_IN_PROGRESS)
            side = 1'b0;
        else if (rd1_reg != ST_IN_PROGRESS)
            side = 1'b1;
        else
            tnull = 1'b1;
    end

    // slot to reclaim in this step
    assign rc_side = (cmd.act == A_TSEL) ? side : oside_reg;
    assign rc_stop = (cmd.act == A_TSEL) ? bank_reg : 1'b1;
    assign rc_id   = slot_id_reg[rc_side];

    assign sts.op       = item_reg.op;
    assign sts.mode     = item_reg.mode;
    assign sts.srch_end = (sidx_reg >= pcount_reg);
    assign sts.hit      = hit;
    assign sts.fit      = fit;
    assign sts.tnull    = tnull;

    // next-state logic
    always_comb
    begin
        pcount_next    = pcount_reg;
        pcursor_next   = pcursor_reg;
        sidx_next      = sidx_reg;
        slot_id_next   = slot_id_reg;
        slot_addr_next = slot_addr_reg;
        tcursor_next   = tcursor_reg;
        nside_next     = nside_reg;
        ovl_next       = ovl_reg;
        oside_next     = oside_reg;
        ret_next       = ret_reg;
        svld_next      = svld_reg;
        res_next       = '0;
        res_vld_next   = 1'b0;

        case (cmd.act)
            A_LATCH:
            begin
                sidx_next = '0;
            end
            A_STATUS:
            begin
                if (32'(item_reg.item_id) < STATUS_DEPTH)
                    svld_next[id_i] = 1'b1;
                res_next.ok   = 1'b1;
                res_next.last = 1'b1;
                res_vld_next  = 1'b1;
            end
            A_CLEAR:
            begin
                pcount_next       = '0;
                pcursor_next      = {1'b0, pbase_reg};
                slot_id_next[0]   = SLOT_EMPTY;
                slot_id_next[1]   = SLOT_EMPTY;
                slot_addr_next[0] = tbase_x;
                slot_addr_next[1] = tend_x;
                tcursor_next      = tbase_x;
                nside_next        = 1'b0;
                res_next.ok       = 1'b1;
                res_next.last     = 1'b1;
                res_vld_next      = 1'b1;
            end
            A_SRCH:
            begin
                sidx_next = sidx_reg + 1'b1;
                if (hit)
                begin
                    res_next.ok      = 1'b1;
                    res_next.address = paddr_mem[sidx_i];
                    res_next.last    = 1'b1;
                    res_vld_next     = 1'b1;
                end
            end
            A_SLOTS:
            begin
                res_next.last = 1'b1;
                res_vld_next  = 1'b1;
                if (slot_id_reg[0] == {1'b0, item_reg.item_id})
                begin
                    nside_next       = 1'b1;
                    res_next.ok      = 1'b1;
                    res_next.address = slot_addr_reg[0][ADDR_W-1:0];
                end
                else if (slot_id_reg[1] == {1'b0, item_reg.item_id})
                begin
                    nside_next       = 1'b0;
                    res_next.ok      = 1'b1;
                    res_next.address = slot_addr_reg[1][ADDR_W-1:0];
                end
            end
            A_NULL:
            begin
                res_next.last = 1'b1;
                res_vld_next  = 1'b1;
            end
            A_PALLOC:
            begin
                if (fit)
                begin
                    pcount_next      = pcount_reg + 1'b1;
                    pcursor_next     = pend_sum[PC_W-1:0];
                    res_next.ok      = 1'b1;
                    res_next.address = pcursor_reg[ADDR_W-1:0];
                    res_next.last    = 1'b1;
                    res_vld_next     = 1'b1;
                end
                else if (item_reg.mode != MODE_FALLBK)
                begin
                    res_next.last = 1'b1;
                    res_vld_next  = 1'b1;
                end
            end
            A_TSEL:
            begin
                if (tnull)
                begin
                    res_next.last = 1'b1;
                    res_vld_next  = 1'b1;
                end
                else
                begin
                    // first reclaim of the chosen side
                    if (rc_id != SLOT_EMPTY)
                    begin
                        if (32'(rc_id) < STATUS_DEPTH)
                            svld_next[rc_id[STAT_AW-1:0]] = 1'b0;
                        res_next.kind       = 1'b1;
                        res_next.address    = slot_addr_reg[rc_side][ADDR_W-1:0];
                        res_next.evicted_id = rc_id[ID_W-1:0];
                        res_next.stop_users = rc_stop;
                        res_vld_next        = 1'b1;
                    end
                    slot_id_next[side] = {1'b0, item_reg.item_id};
                    oside_next         = ~side;
                    nside_next         = ~side;
                    if (!side)
                    begin
                        slot_addr_next[0] = tbase_x;
                        tcursor_next      = tcur0_x;
                        ovl_next          = (slot_addr_reg[1] < tcur0_x);
                        ret_next          = tbase_x[ADDR_W-1:0];
                    end
                    else
                    begin
                        slot_addr_next[1] = new1_x;
                        ovl_next          = (new1_x < tcursor_reg);
                        ret_next          = new1_x[ADDR_W-1:0];
                    end
                end
            end
            A_TOVL:
            begin
                if (ovl_reg)
                begin
                    if (rc_id != SLOT_EMPTY)
                    begin
                        if (32'(rc_id) < STATUS_DEPTH)
                            svld_next[rc_id[STAT_AW-1:0]] = 1'b0;
                        res_next.kind       = 1'b1;
                        res_next.address    = slot_addr_reg[rc_side][ADDR_W-1:0];
                        res_next.evicted_id = rc_id[ID_W-1:0];
                        res_next.stop_users = rc_stop;
                        res_vld_next        = 1'b1;
                    end
                    slot_id_next[rc_side] = SLOT_EMPTY;
                    if (rc_side)
                        slot_addr_next[1] = tend_x;
                    else
                        tcursor_next = tbase_x;
                end
            end
            A_TFIN:
            begin
                res_next.ok      = 1'b1;
                res_next.address = ret_reg;
                res_next.last    = 1'b1;
                res_vld_next     = 1'b1;
            end
            default:
            begin
            end
        endcase

        // register writes; the user must write only while idle, the block does not enforce it
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_PBASE:
                begin
                    pcount_next  = '0;
                    pcursor_next = {1'b0, cfg_data[ADDR_W-1:0]};
                end
                CFG_PLEN:
                begin
                    pcount_next  = '0;
                    pcursor_next = {1'b0, pbase_reg};
                end
                CFG_TBASE:
                begin
                    slot_id_next[0]   = SLOT_EMPTY;
                    slot_id_next[1]   = SLOT_EMPTY;
                    slot_addr_next[0] = {{(TW-ADDR_W){1'b0}}, cfg_data[ADDR_W-1:0]};
                    slot_addr_next[1] = {{(TW-ADDR_W){1'b0}}, cfg_data[ADDR_W-1:0]}
                                        + {{(TW-ADDR_W){1'b0}}, tlen_reg};
                    tcursor_next      = {{(TW-ADDR_W){1'b0}}, cfg_data[ADDR_W-1:0]};
                    nside_next        = 1'b0;
                end
                CFG_TLEN:
                begin
                    slot_id_next[0]   = SLOT_EMPTY;
                    slot_id_next[1]   = SLOT_EMPTY;
                    slot_addr_next[0] = tbase_x;
                    slot_addr_next[1] = tbase_x + {{(TW-ADDR_W){1'b0}}, cfg_data[ADDR_W-1:0]};
                    tcursor_next      = tbase_x;
                    nside_next        = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // control and pool state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pbase_reg        <= '0;
            plen_reg         <= '0;
            tbase_reg        <= '0;
            tlen_reg         <= '0;
            bank_reg         <= 1'b0;
            pcount_reg       <= '0;
            pcursor_reg      <= '0;
            sidx_reg         <= '0;
            slot_id_reg[0]   <= SLOT_EMPTY;
            slot_id_reg[1]   <= SLOT_EMPTY;
            slot_addr_reg[0] <= '0;
            slot_addr_reg[1] <= '0;
            tcursor_reg      <= '0;
            nside_reg        <= 1'b0;
            ovl_reg          <= 1'b0;
            oside_reg        <= 1'b0;
            svld_reg         <= '0;
            res_vld_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PBASE: pbase_reg <= cfg_data[ADDR_W-1:0];
                    CFG_PLEN:  plen_reg  <= cfg_data[ADDR_W-1:0];
                    CFG_TBASE: tbase_reg <= cfg_data[ADDR_W-1:0];
                    CFG_TLEN:  tlen_reg  <= cfg_data[ADDR_W-1:0];
                    CFG_BANK:  bank_reg  <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            pcount_reg    <= pcount_next;
            pcursor_reg   <= pcursor_next;
            sidx_reg      <= sidx_next;
            slot_id_reg   <= slot_id_next;
            slot_addr_reg <= slot_addr_next;
            tcursor_reg   <= tcursor_next;
            nside_reg     <= nside_next;
            ovl_reg       <= ovl_next;
            oside_reg     <= oside_next;
            svld_reg      <= svld_next;
            res_vld_reg   <= res_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.act == A_LATCH)
            item_reg <= in_item;
        if (cmd.act == A_MUL)
            prod_reg <= PROD_W'(item_reg.size_bytes) * PROD_W'(item_reg.unit_count);
        ret_reg <= ret_next;
        res_reg <= res_next;
    end

    // load status table, registered reads of both slot ids
    always_ff @(posedge clk)
    begin
        if (cmd.act == A_STATUS && 32'(item_reg.item_id) < STATUS_DEPTH)
            status_mem[id_i] <= item_reg.new_status;
        if (cmd.act == A_TRD)
        begin
            rd0_reg <= (32'(slot_id_reg[0]) < STATUS_DEPTH
                        && svld_reg[slot_id_reg[0][STAT_AW-1:0]])
                       ? status_mem[slot_id_reg[0][STAT_AW-1:0]] : ST_NOT_LOADED;
            rd1_reg <= (32'(slot_id_reg[1]) < STATUS_DEPTH
                        && svld_reg[slot_id_reg[1][STAT_AW-1:0]])
                       ? status_mem[slot_id_reg[1][STAT_AW-1:0]] : ST_NOT_LOADED;
        end
    end

    // persistent list
    always_ff @(posedge clk)
    begin
        if (cmd.act == A_PALLOC && fit)
        begin
            pid_mem[pcount_reg[PIDX_W-1:0]]   <= item_reg.item_id;
            paddr_mem[pcount_reg[PIDX_W-1:0]] <= pcursor_reg[ADDR_W-1:0];
        end
    end

    assign result       = res_reg;
    assign result_valid = res_vld_reg;

    `TSAPA_ASSERT(a_pcount_max, 1'b1, pcount_reg <= PCNT_W'(PERSIST_ENTRIES), "persistent count overflow")
    `TSAPA_ASSERT(a_last_final, res_vld_reg, res_reg.last == !res_reg.kind, "last flag not on final result")

endmodule

>>> hdl/two_sided_audio_pool_allocator_core.sv
// Top level of the two-sided pool allocator: controller and datapath
//
// channel   | handshake            | payload
// ----------+----------------------+-------------------------------
// request   | start / busy         | cmd (in_t)
// result    | result_valid strobe  | result (res_t)
// config    | cfg_we               | cfg_index, cfg_data
//
// Status and clear are answered from dispatch; a lookup compares one list
// entry per cycle; a persistent grant multiplies, then checks the fit. A
// temporary one steps through status read, side choice, overlap and final,
// also after a fallback; with both slots still loading it answers null.
// Notices go out one per cycle ahead of the final result, which carries last.
// Reset empties both regions and marks every item not loaded at once.
// Results cannot be held off; busy drops as the final result is formed.
module two_sided_audio_pool_allocator_core
    import tsapa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  in_t                  cmd,
    output res_t                 result,
    output logic                 result_valid,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    ctl_cmd_t ctl;
    dp_sts_t  sts;

    tsapa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (ctl)
    );

    tsapa_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_item      (cmd),
        .cmd          (ctl),
        .sts          (sts),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule
